// ===== rtl/core/ttp_pkg.sv =====
// ----------------------------------------------------------------------------
// ttp_pkg: shared types and constants of the task timing profiler
// Event codes, queue entry layout, and the constants for scaling
// raw timestamps to microseconds and milliseconds.
// ----------------------------------------------------------------------------
package ttp_pkg;

  // Number of tasks that are profiled; task indexes at or above it are dropped.
  localparam int TASKS = 8;

  // Field widths fixed by the stream format.
  localparam int TASK_W = 3;
  localparam int TS_W   = 32;
  localparam int US_W   = 26;
  localparam int MS_W   = 16;
  localparam int MIN_W  = 32;
  localparam int NUM_SLOTS = 2 ** TASK_W;

  localparam longint unsigned TS_ALL_ONES = 64'hFFFF_FFFF;
  localparam longint unsigned US_DIV = 64'd80;
  localparam longint unsigned MS_DIV = 64'd80000;

  localparam logic [US_W-1:0] US_LIMIT = US_W'(TS_ALL_ONES / US_DIV);
  localparam logic [MS_W-1:0] MS_LIMIT = MS_W'(TS_ALL_ONES / MS_DIV);

  // ts / 80 = (ts >> 4) / 5 and ts / 80000 = (ts >> 7) / 625. The odd
  // divisors are done by multiplying with a rounded-up reciprocal; the
  // rounding error stays below one quotient step over the full input range.
  localparam int US_SHIFT = 4;
  localparam int MS_SHIFT = 7;
  localparam longint unsigned US_ODD = 64'd5;
  localparam longint unsigned MS_ODD = 64'd625;
  localparam int US_FRAC = 30;
  localparam int MS_FRAC = 34;
  localparam int US_X_W  = TS_W - US_SHIFT;
  localparam int MS_X_W  = TS_W - MS_SHIFT;
  localparam logic [US_X_W-1:0] US_RECIP =
    US_X_W'(((64'd1 << US_FRAC) + US_ODD - 64'd1) / US_ODD);
  localparam logic [MS_X_W-1:0] MS_RECIP =
    MS_X_W'(((64'd1 << MS_FRAC) + MS_ODD - 64'd1) / MS_ODD);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STOP  = 1'b1
  } op_t;

  typedef enum logic {
    KIND_CALL = 1'b0,
    KIND_RUN  = 1'b1
  } kind_t;

  // One classified event as it travels from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic [TASK_W-1:0] task_id;
    logic [US_W-1:0]   now_us;
    logic [MS_W-1:0]   now_ms;
  } ev_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic can_push;
    logic has_data;
  } q_sts_t;

endpackage

// ===== rtl/core/ttp_front.sv =====
// ----------------------------------------------------------------------------
// ttp_front: event intake
// Accepts events, drops those of unknown tasks, and scales the timestamp
// to microseconds and milliseconds before handing the event to the queue.
// ----------------------------------------------------------------------------
module ttp_front import ttp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  op_t               in_op,
  input  logic [TASK_W-1:0] in_task,
  input  logic [TS_W-1:0]   in_ts,
  input  q_sts_t            q_sts,
  output logic              q_push,
  output ev_t               q_ev
);

  logic [2*US_X_W-1:0] prod_us;
  logic [2*MS_X_W-1:0] prod_ms;
  logic                accept;
  logic                task_ok;
  logic                valid_r;
  ev_t                 ev_r;

  assign prod_us = (2*US_X_W)'(in_ts[TS_W-1:US_SHIFT]) * (2*US_X_W)'(US_RECIP);
  assign prod_ms = (2*MS_X_W)'(in_ts[TS_W-1:MS_SHIFT]) * (2*MS_X_W)'(MS_RECIP);

  assign task_ok  = (int'(in_task) < TASKS);
  assign in_ready = !valid_r || q_sts.can_push;
  assign accept   = in_valid && in_ready;
  assign q_push   = valid_r && q_sts.can_push;
  assign q_ev     = ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= task_ok;
    end else if (q_push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_r.op      <= in_op;
      ev_r.task_id <= in_task;
      ev_r.now_us  <= prod_us[US_FRAC +: US_W];
      ev_r.now_ms  <= prod_ms[MS_FRAC +: MS_W];
    end
  end

endmodule

// ===== rtl/core/ttp_queue.sv =====
// ----------------------------------------------------------------------------
// ttp_queue: two-entry event queue
// Decouples the intake from the statistics update so each side can stall.
// ----------------------------------------------------------------------------
module ttp_queue import ttp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  q_ctl_t ctl,
  input  ev_t    push_ev,
  output q_sts_t sts,
  output ev_t    head_ev
);

  ev_t        mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign sts.can_push = (count_r != 2'd2);
  assign sts.has_data = (count_r != 2'd0);
  assign do_push      = ctl.push && sts.can_push;
  assign do_pop       = ctl.pop && sts.has_data;
  assign head_ev      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

endmodule

// ===== rtl/core/ttp_back.sv =====
// ----------------------------------------------------------------------------
// ttp_back: statistics update
// Reads the task's entry, measures the elapsed time with the wrap rule,
// folds it into the minimum and maximum, and registers the result.
// ----------------------------------------------------------------------------
module ttp_back import ttp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_sts_t            q_sts,
  input  ev_t               q_ev,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output kind_t             out_kind,
  output logic [TASK_W-1:0] out_task,
  output logic [US_W-1:0]   out_elapsed,
  output logic [MIN_W-1:0]  out_min,
  output logic [US_W-1:0]   out_max
);

  logic [US_W-1:0]  run_start_r  [NUM_SLOTS];
  logic [MIN_W-1:0] run_min_r    [NUM_SLOTS];
  logic [US_W-1:0]  run_max_r    [NUM_SLOTS];
  logic [MS_W-1:0]  call_start_r [NUM_SLOTS];
  logic [MIN_W-1:0] call_min_r   [NUM_SLOTS];
  logic [MS_W-1:0]  call_max_r   [NUM_SLOTS];

  logic              valid_r;
  logic [TASK_W-1:0] t;
  logic              is_stop;
  logic [US_W-1:0]   base;
  logic [US_W-1:0]   now;
  logic [US_W-1:0]   limit;
  logic [US_W:0]     span;
  logic [US_W-1:0]   el;
  logic [MIN_W-1:0]  cur_min;
  logic [US_W-1:0]   cur_max;
  logic [MIN_W-1:0]  new_min;
  logic [US_W-1:0]   new_max;

  assign q_pop     = q_sts.has_data && (!valid_r || out_ready);
  assign out_valid = valid_r;

  always_comb begin
    t       = q_ev.task_id;
    is_stop = (q_ev.op == OP_STOP);
    if (is_stop) begin
      base    = run_start_r[t];
      now     = q_ev.now_us;
      limit   = US_LIMIT;
      cur_min = run_min_r[t];
      cur_max = run_max_r[t];
    end else begin
      base    = US_W'(call_start_r[t]);
      now     = US_W'(q_ev.now_ms);
      limit   = US_W'(MS_LIMIT);
      cur_min = call_min_r[t];
      cur_max = US_W'(call_max_r[t]);
    end
    // A stored start that is not below the new value is taken as a wrap.
    if (base < now) begin
      span = (US_W+1)'(now) - (US_W+1)'(base);
    end else begin
      span = (US_W+1)'(limit) - (US_W+1)'(base) + (US_W+1)'(now);
    end
    el      = is_stop ? span[US_W-1:0] : US_W'(span[MS_W-1:0]);
    new_min = (MIN_W'(el) < cur_min) ? MIN_W'(el) : cur_min;
    new_max = (el > cur_max) ? el : cur_max;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        run_start_r[i]  <= '0;
        run_min_r[i]    <= '1;
        run_max_r[i]    <= '0;
        call_start_r[i] <= '0;
        call_min_r[i]   <= '1;
        call_max_r[i]   <= '0;
      end
    end else if (q_pop) begin
      valid_r <= 1'b1;
      if (is_stop) begin
        run_min_r[t] <= new_min;
        run_max_r[t] <= new_max;
      end else begin
        run_start_r[t]  <= q_ev.now_us;
        call_start_r[t] <= q_ev.now_ms;
        call_min_r[t]   <= new_min;
        call_max_r[t]   <= new_max[MS_W-1:0];
      end
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_kind    <= is_stop ? KIND_RUN : KIND_CALL;
      out_task    <= t;
      out_elapsed <= el;
      out_min     <= new_min;
      out_max     <= new_max;
    end
  end

endmodule

// ===== rtl/core/task_timing_profiler.sv =====
// ----------------------------------------------------------------------------
// task_timing_profiler: per-task run time and call interval profiler
// Keeps, for every task, the minimum and maximum run time in microseconds
// and the minimum and maximum interval between starts in milliseconds.
// ----------------------------------------------------------------------------
// Path: an accepted transaction passes the front-end register, the queue entry
//   and the result register, in that order, before its result shows on out_*.
// Throughput: one event per cycle while out_tready stays high; the limit is
//   the single read-modify-write port on the per-task statistics table.
// Reset (rst_n low, synchronous): queue and output are emptied, minimums go
//   to all ones and starts and maximums to zero, in the same cycle.
// ----------------------------------------------------------------------------
module task_timing_profiler import ttp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Event channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] task_req, [34:3] timestamp, [39:35] zero
  input  logic        in_tuser,   // [0] opcode: 0 start of run, 1 end of run
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [2:0] task_echo, [28:3] elapsed,
                                  // [60:29] minimum, [86:61] maximum, [87] zero
  output logic        out_tuser   // [0] kind: 0 call interval, 1 run time
);

  // The front end does the timestamp scaling: both divisions are reciprocal
  // multiplies whose products are registered before the event is queued.
  q_ctl_t            q_ctl;
  q_sts_t            q_sts;
  logic              q_push;
  logic              q_pop;
  ev_t               push_ev;
  ev_t               head_ev;
  kind_t             res_kind;
  logic [TASK_W-1:0] res_task;
  logic [US_W-1:0]   res_elapsed;
  logic [MIN_W-1:0]  res_min;
  logic [US_W-1:0]   res_max;

  assign q_ctl = '{push: q_push, pop: q_pop};

  ttp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (op_t'(in_tuser)),
    .in_task  (in_tdata[2:0]),
    .in_ts    (in_tdata[34:3]),
    .q_sts    (q_sts),
    .q_push   (q_push),
    .q_ev     (push_ev)
  );

  // Two entries are enough to let the queue take one more event from the front
  // after the result side stalls.
  ttp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .push_ev (push_ev),
    .sts     (q_sts),
    .head_ev (head_ev)
  );

  // The back end updates the task's entry and loads the result register in
  // the same cycle, so a following event of the same task sees fresh values.
  ttp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_sts       (q_sts),
    .q_ev        (head_ev),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (res_kind),
    .out_task    (res_task),
    .out_elapsed (res_elapsed),
    .out_min     (res_min),
    .out_max     (res_max)
  );

  assign out_tuser = (res_kind == KIND_RUN);
  assign out_tdata = {1'b0, res_max, res_min, res_elapsed, res_task};

endmodule

// ===== rtl/core/ttp_checker.sv =====
// ----------------------------------------------------------------------------
// ttp_checker: port-level checks of the task timing profiler
// Watches the result channel for ordering of statistics and reset behavior.
// ----------------------------------------------------------------------------
module ttp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic        out_tuser
);

  // A result held under back-pressure must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The reported maximum already includes the new measurement.
  a_max_ge_el: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[86:61] >= out_tdata[28:3])
    else $error("maximum below elapsed");

  // The reported minimum already includes the new measurement.
  a_min_le_el: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[60:29] <= {6'd0, out_tdata[28:3]})
    else $error("minimum above elapsed");

  // Call intervals are millisecond counts that fit in sixteen bits.
  a_call_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[28:19] == 10'd0 && out_tdata[86:77] == 10'd0)
    else $error("call interval too wide");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind task_timing_profiler ttp_checker u_ttp_checker (.*);
